>>> rtl/cma_pkg.sv
// Shared constants, types and helpers for the circular moving average block.
// Used by the controller, datapath, divider and top level; depends on nothing.
package cma_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_WINDOW   = 64;
  localparam int PTR_BITS     = $clog2(MAX_WINDOW);
  localparam int WIN_BITS     = 7;
  localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // take the input item
    logic read;        // issue ring and head memory reads
    logic add;         // push one value into the window
    logic from_head;   // pushed value comes from the head store
    logic div_start;   // start the serial divide of the window sum
    logic emit;        // load the output register
    logic emit_last;   // mark the result as the final one of the sequence
    logic emit_short;  // result is the too-short marker
    logic next_k;      // advance the flush index
    logic clear;       // clear sequence state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eos;          // held item ends the sequence
    logic below_window; // fewer than W samples after this push
    logic w_one;        // window of one
    logic flush_last;   // flush index is at the final wrapped average
    logic div_done;     // divider finished
    logic out_free;     // output register can take a result
  } status_t;

  // Clamp the raw window register to 1..MAX_WINDOW.
  function automatic logic [WIN_BITS-1:0] clamp_window(input logic [WIN_BITS-1:0] w);
    logic [WIN_BITS-1:0] r;
    if (w == '0) begin
      r = WIN_BITS'(1);
    end else if (w > WIN_BITS'(MAX_WINDOW)) begin
      r = WIN_BITS'(MAX_WINDOW);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

>>> rtl/cma_divider.sv
// Serial restoring divider: signed window sum over unsigned window length,
// truncating toward zero, one quotient bit per cycle. Depends on cma_pkg.
module cma_divider
  import cma_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SUM_BITS-1:0]    dividend,
  input  logic        [WIN_BITS-1:0]    divisor,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] quotient
);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] count;
  logic [WIN_BITS-1:0]     rem;
  logic [SUM_BITS-1:0]     quo;
  logic [WIN_BITS-1:0]     div_q;
  logic                    neg;

  logic [WIN_BITS:0]       trial;
  logic                    take;
  logic [WIN_BITS:0]       diff;
  logic [SAMPLE_BITS-1:0]  mag;

  assign trial = {rem, quo[SUM_BITS-1]};
  assign take  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};
  assign mag   = quo[SAMPLE_BITS-1:0];
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= DIV_CNT_BITS'(SUM_BITS - 1);
      rem   <= '0;
      // work on the magnitude, fix the sign at the end
      quo   <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      neg   <= dividend[SUM_BITS-1];
      div_q <= divisor;
    end else if (busy) begin
      count <= count - DIV_CNT_BITS'(1);
      rem   <= take ? diff[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
      quo   <= {quo[SUM_BITS-2:0], take};
    end
  end

endmodule

>>> rtl/cma_datapath.sv
// Datapath: window register, ring and head sample memories, window sum,
// sequence counters, serial divider and output register. Depends on cma_pkg.
module cma_datapath
  import cma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   cfg_wr_en,
  input  logic [WIN_BITS-1:0]    cfg_wr_data,
  input  logic [SAMPLE_BITS-1:0] s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [SAMPLE_BITS-1:0] m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  logic [WIN_BITS-1:0]           window_length;
  logic [WIN_BITS-1:0]           w_use;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          eos_q;
  logic signed [SUM_BITS-1:0]    window_sum;
  logic [WIN_BITS-1:0]           samples_seen;
  logic [PTR_BITS-1:0]           ring_pointer;
  logic [PTR_BITS-1:0]           flush_k;

  logic signed [SAMPLE_BITS-1:0] recent_mem [0:MAX_WINDOW-1];
  logic signed [SAMPLE_BITS-1:0] head_mem   [0:MAX_WINDOW-2];
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic signed [SAMPLE_BITS-1:0] head_q;

  logic [PTR_BITS-1:0]           old_addr;
  logic [WIN_BITS-1:0]           seen_inc;
  logic                          full;
  logic                          head_wr;
  logic signed [SAMPLE_BITS-1:0] push_val;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign old_addr = ring_pointer - w_use[PTR_BITS-1:0];
  assign seen_inc = (samples_seen == WIN_BITS'(MAX_WINDOW)) ? samples_seen
                                                            : samples_seen + WIN_BITS'(1);
  // flush pushes always drop the oldest value
  assign full     = cmd.from_head || (samples_seen >= w_use);
  assign head_wr  = !cmd.from_head && ((samples_seen + WIN_BITS'(1)) < w_use);
  assign push_val = cmd.from_head ? head_q : sample_q;
  assign sum_next = window_sum + SUM_BITS'(push_val)
                  - (full ? SUM_BITS'(old_q) : SUM_BITS'(0));

  assign status.eos          = eos_q;
  assign status.below_window = seen_inc < w_use;
  assign status.w_one        = w_use == WIN_BITS'(1);
  assign status.flush_last   = (WIN_BITS'(flush_k) + WIN_BITS'(2)) == w_use;
  assign status.div_done     = div_done;
  assign status.out_free     = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_BITS'(1);
    end else if (cfg_wr_en) begin
      window_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_use        <= WIN_BITS'(1);
      window_sum   <= '0;
      samples_seen <= '0;
      ring_pointer <= '0;
      flush_k      <= '0;
    end else begin
      if (cmd.load && samples_seen == '0) begin
        w_use <= clamp_window(window_length);
      end
      if (cmd.clear) begin
        window_sum   <= '0;
        samples_seen <= '0;
        ring_pointer <= '0;
        flush_k      <= '0;
      end else begin
        if (cmd.add) begin
          window_sum   <= sum_next;
          ring_pointer <= ring_pointer + PTR_BITS'(1);
          if (!cmd.from_head) begin
            samples_seen <= seen_inc;
          end
        end
        if (cmd.next_k) begin
          flush_k <= flush_k + PTR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= s_tdata;
      eos_q    <= s_tlast;
    end
  end

  // ring of recent samples: read the value leaving the window, then overwrite
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      old_q <= recent_mem[old_addr];
    end
    if (cmd.add) begin
      recent_mem[ring_pointer] <= push_val;
    end
  end

  // first W-1 samples, replayed during the wrap-around flush
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      head_q <= head_mem[flush_k];
    end
    if (cmd.add && head_wr) begin
      head_mem[samples_seen[PTR_BITS-1:0]] <= sample_q;
    end
  end

  cma_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (window_sum),
    .divisor  (w_use),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= cmd.emit_short ? '0 : div_quot;
      m_tlast <= cmd.emit_last;
      m_tuser <= cmd.emit_short;
    end
  end

endmodule

>>> rtl/cma_ctrl.sv
// Controller: sequences accept, memory read, window update, divide and emit
// for each item and for the wrap-around flush. Depends on cma_pkg.
module cma_ctrl
  import cma_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_ADD   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   flushing, flushing_next;
  logic   short_pend, short_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flushing   <= 1'b0;
      short_pend <= 1'b0;
    end else begin
      state      <= state_next;
      flushing   <= flushing_next;
      short_pend <= short_pend_next;
    end
  end

  always_comb begin
    state_next      = state;
    flushing_next   = flushing;
    short_pend_next = short_pend;
    cmd             = '0;
    s_tready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load        = 1'b1;
          flushing_next   = 1'b0;
          short_pend_next = 1'b0;
          state_next      = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add       = 1'b1;
        cmd.from_head = flushing;
        if (!flushing && status.below_window) begin
          if (status.eos) begin
            short_pend_next = 1'b1;
            state_next      = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register frees up
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_short = short_pend;
          if (short_pend) begin
            cmd.emit_last = 1'b1;
            cmd.clear     = 1'b1;
            state_next    = S_IDLE;
          end else if (flushing) begin
            cmd.emit_last = status.flush_last;
            if (status.flush_last) begin
              cmd.clear  = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.next_k = 1'b1;
              state_next = S_READ;
            end
          end else begin
            cmd.emit_last = status.eos && status.w_one;
            if (status.eos && !status.w_one) begin
              flushing_next = 1'b1;
              state_next    = S_READ;
            end else begin
              cmd.clear  = status.eos;
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/circular_moving_average.sv
// Circular moving average over a sample sequence: one box average per sample
// with the window wrapping to the start of the sequence at its end.
// Top level joining cma_ctrl and cma_datapath; depends on cma_pkg.
//
// Each input item is a Q8.16 sample; tlast marks the last sample of a
// sequence. Once W samples are in, every sample gives one average of the
// last W samples, truncated toward zero, and the last sample also gives the
// W-1 averages that wrap over the first samples. A sequence shorter than W
// gives one item with average 0, tlast and tuser (too short) set. W is taken
// from the window register at the first sample of a sequence, clamped to
// 1..64. Every average goes through a one-bit-per-cycle divider over the
// 30-bit window sum, so an item that yields an average passes through
// accept, read, update, divide start, the divide steps and done, then
// emit, which waits until the output register is free; each flushed
// average repeats read through emit. An item that yields nothing passes
// accept, read and update, and the last item of a too-short sequence adds
// emit. The output register lets the next item be taken while a result waits.
module circular_moving_average
  import cma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [WIN_BITS-1:0]    cfg_wr_data,  // window_length
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_BITS-1:0] s_tdata,      // sample
  input  logic                   s_tlast,      // end_of_sequence
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_BITS-1:0] m_tdata,      // average
  output logic                   m_tlast,      // last_of_run
  output logic                   m_tuser       // too_short
);

  cmd_t    cmd;
  status_t status;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cma_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

>>> tb/sv/circular_moving_average_tb.sv
// Self-checking testbench for circular_moving_average: directed table, then random sequences.
// Predicts each box average in a local model of the window state; depends on cma_pkg and the RTL.
module circular_moving_average_tb
  import cma_pkg::*;
();

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 300;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   last_of_run;
    logic                   too_short;
  } avg_result_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [WIN_BITS-1:0]    win;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   eos;
    logic                   typed;
    avg_result_t            res;
  } stim_row_t;

  localparam avg_result_t NONE = '{24'h0, 1'b0, 1'b0};
  localparam int DIRECTED_LEN = 29;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // window of one after reset
    '{1'b0, 7'd0, 24'h7FFFFF, 1'b0, 1'b1, '{24'h7FFFFF, 1'b0, 1'b0}},
    '{1'b0, 7'd0, 24'h800000, 1'b0, 1'b1, '{24'h800000, 1'b0, 1'b0}},
    '{1'b0, 7'd0, 24'h000000, 1'b1, 1'b1, '{24'h000000, 1'b1, 1'b0}},
    // zero register acts as a window of one
    '{1'b1, 7'd0, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'hFFFFFF, 1'b1, 1'b1, '{24'hFFFFFF, 1'b1, 1'b0}},
    // too short, then full-scale wrap
    '{1'b1, 7'd3, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd5, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd7, 1'b1, 1'b1, '{24'h000000, 1'b1, 1'b1}},
    '{1'b0, 7'd0, 24'h7FFFFF, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'h7FFFFF, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'h7FFFFF, 1'b1, 1'b0, NONE},
    // oversized register saturates to the largest window
    '{1'b1, 7'd127, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd100, 1'b1, 1'b1, '{24'h000000, 1'b1, 1'b1}},
    // negative sums truncate toward zero
    '{1'b1, 7'd2, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'hFFFFFD, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd2, 1'b1, 1'b0, NONE},
    // register change inside a sequence waits for the next one
    '{1'b1, 7'd3, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'h800000, 1'b0, 1'b0, NONE},
    '{1'b1, 7'd1, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'h800000, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd123456, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'hFFFFFF, 1'b1, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd4, 1'b1, 1'b1, '{24'd4, 1'b1, 1'b0}},
    '{1'b1, 7'd4, 24'h0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd1, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'hFFFFFE, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'd3, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'hFFFFFB, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 24'h7FFFFF, 1'b1, 1'b0, NONE}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [WIN_BITS-1:0]    cfg_wr_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [SAMPLE_BITS-1:0] s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [SAMPLE_BITS-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  // sideband that travels with the offered item
  logic        row_typed;
  avg_result_t row_result;

  int  send_idle = 36;
  int  recv_idle = 82;
  bit  hold_output = 1'b0;
  bit  hold_taken = 1'b0;
  int  errors = 0;

  avg_result_t expected_avgs[$];

  // local copy of the window state
  int                  ring_vals [MAX_WINDOW];
  int                  head_vals [MAX_WINDOW-1];
  int                  window_total = 0;
  int                  fill_count = 0;
  int                  ring_ptr = 0;
  int                  win_in_use = 1;
  logic [WIN_BITS-1:0] win_reg = 7'd1;

  circular_moving_average i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic push_window(input int v, input bit full);
    if (full) begin
      window_total -= ring_vals[(ring_ptr + MAX_WINDOW - win_in_use) % MAX_WINDOW];
    end
    ring_vals[ring_ptr] = v;
    window_total += v;
    ring_ptr = (ring_ptr + 1) % MAX_WINDOW;
  endtask

  task automatic post_average(input int avg, input bit last, input bit short_seq);
    avg_result_t r;
    r = '{SAMPLE_BITS'(avg), last, short_seq};
    expected_avgs = {expected_avgs, r};
  endtask

  task automatic predict_averages(input int s, input bit eos);
    int k;
    if (fill_count == 0) begin
      if (win_reg == '0) win_in_use = 1;
      else if (win_reg > MAX_WINDOW) win_in_use = MAX_WINDOW;
      else win_in_use = win_reg;
    end
    if (fill_count < win_in_use - 1) head_vals[fill_count] = s;
    push_window(s, fill_count >= win_in_use);
    if (fill_count < MAX_WINDOW) fill_count++;
    if (fill_count < win_in_use) begin
      if (eos) begin
        post_average(0, 1'b1, 1'b1);
        window_total = 0;
        fill_count = 0;
        ring_ptr = 0;
      end
      return;
    end
    post_average(window_total / win_in_use, eos && win_in_use == 1, 1'b0);
    if (eos) begin
      // wrap the window over the head of the sequence
      for (k = 0; k < win_in_use - 1; k++) begin
        push_window(head_vals[k], 1'b1);
        post_average(window_total / win_in_use, k + 2 == win_in_use, 1'b0);
      end
      window_total = 0;
      fill_count = 0;
      ring_ptr = 0;
    end
  endtask

  always @(posedge clk) begin
    int          n_before;
    avg_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_avgs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual avg %0d last %0b short %0b",
                   $time, $signed(m_tdata), m_tlast, m_tuser);
        end else begin
          want = expected_avgs.pop_front();
          if (m_tdata !== want.average) begin
            errors++;
            $display("%0t: average mismatch, expected %0d actual %0d",
                     $time, $signed(want.average), $signed(m_tdata));
          end
          if (m_tlast !== want.last_of_run) begin
            errors++;
            $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                     $time, want.last_of_run, m_tlast);
          end
          if (m_tuser !== want.too_short) begin
            errors++;
            $display("%0t: too_short mismatch, expected %0b actual %0b",
                     $time, want.too_short, m_tuser);
          end
        end
      end
      if (cfg_wr_en) win_reg = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        n_before = expected_avgs.size();
        predict_averages($signed(s_tdata), s_tlast);
        if (row_typed) begin
          // replace the predicted item with the one typed in the table
          while (expected_avgs.size() > n_before) void'(expected_avgs.pop_back());
          expected_avgs = {expected_avgs, row_result};
        end
      end
    end
  end

  // receiver: random backpressure, one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled = 0;
      else stalled++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] d, input logic l,
                             input logic typed, input avg_result_t res);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= d;
    s_tlast    <= l;
    row_typed  <= typed;
    row_result <= res;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, let every expected item arrive, then let the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_BITS-1:0] w);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int                     items_sent;
    int                     seq_len;
    int                     eff_win;
    int                     r;
    int                     k;
    int                     seq_idx;
    bit                     hold_seq;
    logic [WIN_BITS-1:0]    cur_win;
    logic [SAMPLE_BITS-1:0] d;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    row_typed   = 1'b0;
    row_result  = NONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_ROWS[i].is_cfg) begin
        write_window(DIRECTED_ROWS[i].win);
      end else begin
        send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].eos,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end
    end
    cur_win = 7'd4;

    items_sent = 0;
    seq_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle = 36;
        recv_idle = 82;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 82;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      hold_seq = 1'b0;
      if (seq_idx == 0 || (send_idle == 0 && !hold_output)) begin
        // largest window; in the last phase also hold the output off so the block backs up
        write_window(7'd64);
        cur_win = 7'd64;
        if (send_idle == 0) begin
          hold_output = 1'b1;
          hold_seq    = 1'b1;
        end
      end else if ($urandom_range(99) < 75) begin
        r = $urandom_range(99);
        if (r < 6) cur_win = 7'd0;
        else if (r < 10) cur_win = WIN_BITS'($urandom_range(127, 65));
        else if (r < 13) cur_win = 7'd64;
        else cur_win = WIN_BITS'($urandom_range(10, 1));
        write_window(cur_win);
      end

      if (cur_win == '0) eff_win = 1;
      else if (cur_win > MAX_WINDOW) eff_win = MAX_WINDOW;
      else eff_win = cur_win;

      if (eff_win > 1 && $urandom_range(99) < 15) begin
        seq_len = $urandom_range(eff_win - 1, 1);
      end else if (eff_win > 16) begin
        seq_len = eff_win + $urandom_range(6);
      end else begin
        seq_len = eff_win + $urandom_range(2 * eff_win + 6);
      end
      // keep offering items after the held block has backed up
      if (hold_seq) seq_len = eff_win + 4 + $urandom_range(6);

      for (k = 0; k < seq_len; k++) begin
        r = $urandom_range(99);
        if (r < 8) d = 24'h7FFFFF;
        else if (r < 16) d = 24'h800000;
        else d = SAMPLE_BITS'($urandom);
        send_sample(d, k == seq_len - 1, 1'b0, NONE);
        items_sent++;
      end
      seq_idx++;
    end

    wait_idle();
    errors += expected_avgs.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cma_pkg.sv
rtl/cma_divider.sv
rtl/cma_datapath.sv
rtl/cma_ctrl.sv
rtl/circular_moving_average.sv
tb/sv/circular_moving_average_tb.sv
